[rtl/core/tcce_pkg.sv]
// Shared constants, types and codes for the text console cursor editor.
`default_nettype none

package tcce_pkg;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int SCREEN_CELLS = COLUMNS * ROWS;
  // One extra invisible cell sits just past the last visible cell.
  localparam int ADDR_W       = $clog2(SCREEN_CELLS + 1);
  localparam int CURSOR_W     = 11;
  localparam int INDEX_W      = 11;
  localparam int BYTE_W       = 8;
  localparam int CELL_W       = 2 * BYTE_W;
  localparam int OP_W         = 4;
  localparam int CFG_IDX_W    = 2;

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CURSOR_W-1:0]  cursor_t;
  typedef logic [INDEX_W-1:0]   index_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CELL_W-1:0]    cell_t;
  typedef logic [OP_W-1:0]      op_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam op_t OP_WRITE  = 4'd0;
  localparam op_t OP_PUT    = 4'd1;
  localparam op_t OP_CLEAR  = 4'd2;
  localparam op_t OP_LEFT   = 4'd3;
  localparam op_t OP_RIGHT  = 4'd4;
  localparam op_t OP_UP     = 4'd5;
  localparam op_t OP_DOWN   = 4'd6;
  localparam op_t OP_DELETE = 4'd7;
  localparam op_t OP_BKSP   = 4'd8;
  localparam op_t OP_READ   = 4'd9;

  localparam cfg_idx_t CFG_PUT_COLOR   = 2'd0;
  localparam cfg_idx_t CFG_CURSOR_MARK = 2'd1;
  localparam cfg_idx_t CFG_PLAIN_ATTR  = 2'd2;

  localparam byte_t PUT_COLOR_RST   = 8'd15;
  localparam byte_t CURSOR_MARK_RST = 8'd232;
  localparam byte_t PLAIN_ATTR_RST  = 8'd15;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_PUT,
    S_MARK_RD,
    S_MARK_WR,
    S_OLD_RD,
    S_OLD_WR,
    S_NEW_RD,
    S_NEW_WR,
    S_DEL_START,
    S_DEL_SHIFT,
    S_DEL_LAST,
    S_CLR,
    S_READ_RD,
    S_READ_CAP,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_INIT_WR,
    CMD_PUT_WR,
    CMD_MARK_RD,
    CMD_MARK_WR,
    CMD_OLD_RD,
    CMD_OLD_WR,
    CMD_NEW_RD,
    CMD_NEW_WR,
    CMD_DEL_START,
    CMD_DEL_SHIFT,
    CMD_DEL_LAST,
    CMD_CLR_WR,
    CMD_RD_CELL,
    CMD_RD_CAPTURE,
    CMD_LOAD_OUT
  } cmd_t;

  typedef struct packed {
    logic blocked;         // move or backspace on the input beat hits a bound
    logic near_end;        // cursor on the last visible cell or beyond
    logic ptr_shift_last;  // shift pointer at the last cell that receives a copy
    logic ptr_clr_last;    // clear pointer at the last visible cell
    logic ptr_init_last;   // init pointer at the invisible cell
    logic out_free;        // output register can take a result this cycle
  } status_t;

endpackage

`default_nettype wire

[rtl/core/tcce_ctrl.sv]
// Controller state machine that sequences each operation over the cell store.
`default_nettype none

module tcce_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  input  wire tcce_pkg::op_t      op,
  input  wire tcce_pkg::status_t  status,
  output logic                    in_stall,
  output tcce_pkg::cmd_t          cmd
);

  tcce_pkg::state_t state;
  tcce_pkg::state_t state_next;
  tcce_pkg::op_t    op_q;
  tcce_pkg::op_t    op_q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcce_pkg::S_INIT;
      op_q  <= tcce_pkg::OP_WRITE;
    end else begin
      state <= state_next;
      op_q  <= op_q_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    op_q_next  = op_q;
    case (state)
      tcce_pkg::S_INIT: begin
        if (status.ptr_init_last) state_next = tcce_pkg::S_IDLE;
      end
      tcce_pkg::S_IDLE: begin
        if (in_valid) begin
          op_q_next = op;
          if (status.blocked) begin
            state_next = tcce_pkg::S_DONE;
          end else begin
            case (op)
              tcce_pkg::OP_WRITE, tcce_pkg::OP_PUT: state_next = tcce_pkg::S_PUT;
              tcce_pkg::OP_CLEAR:                   state_next = tcce_pkg::S_CLR;
              tcce_pkg::OP_LEFT, tcce_pkg::OP_RIGHT, tcce_pkg::OP_UP,
              tcce_pkg::OP_DOWN, tcce_pkg::OP_BKSP: state_next = tcce_pkg::S_OLD_RD;
              tcce_pkg::OP_DELETE:                  state_next = tcce_pkg::S_DEL_START;
              tcce_pkg::OP_READ:                    state_next = tcce_pkg::S_READ_RD;
              default:                              state_next = tcce_pkg::S_DONE;
            endcase
          end
        end
      end
      tcce_pkg::S_PUT: begin
        state_next = (op_q == tcce_pkg::OP_PUT) ? tcce_pkg::S_MARK_RD : tcce_pkg::S_DONE;
      end
      tcce_pkg::S_MARK_RD:  state_next = tcce_pkg::S_MARK_WR;
      tcce_pkg::S_MARK_WR:  state_next = tcce_pkg::S_DONE;
      tcce_pkg::S_OLD_RD:   state_next = tcce_pkg::S_OLD_WR;
      tcce_pkg::S_OLD_WR:   state_next = tcce_pkg::S_NEW_RD;
      tcce_pkg::S_NEW_RD:   state_next = tcce_pkg::S_NEW_WR;
      tcce_pkg::S_NEW_WR: begin
        state_next = (op_q == tcce_pkg::OP_BKSP) ? tcce_pkg::S_DEL_START : tcce_pkg::S_DONE;
      end
      tcce_pkg::S_DEL_START: begin
        state_next = status.near_end ? tcce_pkg::S_DONE : tcce_pkg::S_DEL_SHIFT;
      end
      tcce_pkg::S_DEL_SHIFT: begin
        if (status.ptr_shift_last) state_next = tcce_pkg::S_DEL_LAST;
      end
      tcce_pkg::S_DEL_LAST: state_next = tcce_pkg::S_DONE;
      tcce_pkg::S_CLR: begin
        if (status.ptr_clr_last) state_next = tcce_pkg::S_DONE;
      end
      tcce_pkg::S_READ_RD:  state_next = tcce_pkg::S_READ_CAP;
      tcce_pkg::S_READ_CAP: state_next = tcce_pkg::S_DONE;
      tcce_pkg::S_DONE: begin
        if (status.out_free) state_next = tcce_pkg::S_IDLE;
      end
      default: state_next = tcce_pkg::S_INIT;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_stall = 1'b1;
    cmd      = tcce_pkg::CMD_NONE;
    case (state)
      tcce_pkg::S_INIT:      cmd = tcce_pkg::CMD_INIT_WR;
      tcce_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd = tcce_pkg::CMD_ACCEPT;
      end
      tcce_pkg::S_PUT:       cmd = tcce_pkg::CMD_PUT_WR;
      tcce_pkg::S_MARK_RD:   cmd = tcce_pkg::CMD_MARK_RD;
      tcce_pkg::S_MARK_WR:   cmd = tcce_pkg::CMD_MARK_WR;
      tcce_pkg::S_OLD_RD:    cmd = tcce_pkg::CMD_OLD_RD;
      tcce_pkg::S_OLD_WR:    cmd = tcce_pkg::CMD_OLD_WR;
      tcce_pkg::S_NEW_RD:    cmd = tcce_pkg::CMD_NEW_RD;
      tcce_pkg::S_NEW_WR:    cmd = tcce_pkg::CMD_NEW_WR;
      tcce_pkg::S_DEL_START: cmd = tcce_pkg::CMD_DEL_START;
      tcce_pkg::S_DEL_SHIFT: cmd = tcce_pkg::CMD_DEL_SHIFT;
      tcce_pkg::S_DEL_LAST:  cmd = tcce_pkg::CMD_DEL_LAST;
      tcce_pkg::S_CLR:       cmd = tcce_pkg::CMD_CLR_WR;
      tcce_pkg::S_READ_RD:   cmd = tcce_pkg::CMD_RD_CELL;
      tcce_pkg::S_READ_CAP:  cmd = tcce_pkg::CMD_RD_CAPTURE;
      tcce_pkg::S_DONE: begin
        if (status.out_free) cmd = tcce_pkg::CMD_LOAD_OUT;
      end
      default: cmd = tcce_pkg::CMD_NONE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/tcce_datapath.sv]
// Datapath: cell store, cursor, work pointer, operand and result registers.
`default_nettype none

module tcce_datapath (
  input  wire                      clk,
  input  wire                      rst,
  input  wire tcce_pkg::cmd_t      cmd,
  input  wire tcce_pkg::op_t       op,
  input  wire tcce_pkg::byte_t     char_code,
  input  wire tcce_pkg::byte_t     color,
  input  wire tcce_pkg::index_t    cell_index,
  input  wire tcce_pkg::byte_t     put_color,
  input  wire tcce_pkg::byte_t     cursor_mark_attr,
  input  wire tcce_pkg::byte_t     plain_attr,
  input  wire                      out_stall,
  output tcce_pkg::status_t        status,
  output logic                     out_valid,
  output tcce_pkg::cursor_t        cursor_now,
  output logic                     refused,
  output tcce_pkg::byte_t          cell_char,
  output tcce_pkg::byte_t          cell_attr
);

  localparam tcce_pkg::addr_t LAST_ADDR  = tcce_pkg::addr_t'(tcce_pkg::SCREEN_CELLS);
  localparam tcce_pkg::addr_t LAST_VIS   = tcce_pkg::addr_t'(tcce_pkg::SCREEN_CELLS - 1);
  localparam tcce_pkg::addr_t LAST_SHIFT = tcce_pkg::addr_t'(tcce_pkg::SCREEN_CELLS - 2);
  localparam tcce_pkg::addr_t COLS_A     = tcce_pkg::addr_t'(tcce_pkg::COLUMNS);
  localparam tcce_pkg::addr_t DOWN_LIMIT =
      tcce_pkg::addr_t'(tcce_pkg::SCREEN_CELLS - tcce_pkg::COLUMNS);
  localparam tcce_pkg::addr_t ONE_A      = tcce_pkg::addr_t'(1);
  localparam tcce_pkg::addr_t TWO_A      = tcce_pkg::addr_t'(2);

  tcce_pkg::cell_t mem [0:tcce_pkg::SCREEN_CELLS];
  tcce_pkg::cell_t rdata;
  logic            we;
  tcce_pkg::addr_t waddr;
  tcce_pkg::cell_t wdata;
  tcce_pkg::addr_t raddr;

  tcce_pkg::addr_t  cursor;
  tcce_pkg::addr_t  ptr;
  tcce_pkg::addr_t  dest;
  tcce_pkg::byte_t  char_q;
  tcce_pkg::byte_t  attr_q;
  tcce_pkg::byte_t  saved;
  tcce_pkg::index_t idx_q;
  logic             refused_flag;
  tcce_pkg::byte_t  res_char;
  tcce_pkg::byte_t  res_attr;

  tcce_pkg::addr_t  put_pos;
  tcce_pkg::addr_t  dest_next;
  logic             blocked;
  logic             idx_ok;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign put_pos = (cursor >= LAST_ADDR) ? '0 : cursor;
  assign idx_ok  = 32'(idx_q) <= tcce_pkg::SCREEN_CELLS;

  always_comb begin
    blocked   = 1'b0;
    dest_next = cursor;
    case (op)
      tcce_pkg::OP_LEFT, tcce_pkg::OP_BKSP: begin
        blocked   = (cursor == '0);
        dest_next = cursor - ONE_A;
      end
      tcce_pkg::OP_RIGHT: begin
        blocked   = (cursor >= LAST_VIS);
        dest_next = cursor + ONE_A;
      end
      tcce_pkg::OP_UP: begin
        blocked   = (cursor < COLS_A);
        dest_next = cursor - COLS_A;
      end
      tcce_pkg::OP_DOWN: begin
        blocked   = (cursor >= DOWN_LIMIT);
        dest_next = cursor + COLS_A;
      end
      default: begin
        blocked   = 1'b0;
        dest_next = cursor;
      end
    endcase
  end

  always_comb begin
    status.blocked        = blocked;
    status.near_end       = (cursor >= LAST_VIS);
    status.ptr_shift_last = (ptr == LAST_SHIFT);
    status.ptr_clr_last   = (ptr == LAST_VIS);
    status.ptr_init_last  = (ptr == LAST_ADDR);
    status.out_free       = !out_valid || !out_stall;
  end

  // Store port control.
  always_comb begin
    we    = 1'b0;
    waddr = cursor;
    wdata = '0;
    raddr = cursor;
    case (cmd)
      tcce_pkg::CMD_INIT_WR: begin
        we    = 1'b1;
        waddr = ptr;
      end
      tcce_pkg::CMD_PUT_WR: begin
        we    = 1'b1;
        waddr = put_pos;
        wdata = {attr_q, char_q};
      end
      tcce_pkg::CMD_MARK_WR: begin
        we    = 1'b1;
        wdata = {cursor_mark_attr, rdata[tcce_pkg::BYTE_W-1:0]};
      end
      tcce_pkg::CMD_OLD_WR: begin
        we    = 1'b1;
        wdata = {plain_attr, rdata[tcce_pkg::BYTE_W-1:0]};
      end
      tcce_pkg::CMD_NEW_WR: begin
        we    = 1'b1;
        wdata = {saved, rdata[tcce_pkg::BYTE_W-1:0]};
      end
      tcce_pkg::CMD_DEL_START: begin
        // At the last visible or invisible cell nothing shifts.
        we    = status.near_end;
        wdata = {cursor_mark_attr, tcce_pkg::byte_t'(0)};
        raddr = cursor + ONE_A;
      end
      tcce_pkg::CMD_DEL_SHIFT: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = (ptr == cursor) ? {cursor_mark_attr, rdata[tcce_pkg::BYTE_W-1:0]} : rdata;
        raddr = ptr + TWO_A;
      end
      tcce_pkg::CMD_DEL_LAST: begin
        we    = 1'b1;
        waddr = LAST_VIS;
      end
      tcce_pkg::CMD_CLR_WR: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = (ptr == '0) ? {cursor_mark_attr, tcce_pkg::byte_t'(0)} : '0;
      end
      tcce_pkg::CMD_RD_CELL: begin
        raddr = idx_ok ? tcce_pkg::addr_t'(idx_q) : '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd == tcce_pkg::CMD_LOAD_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        tcce_pkg::CMD_ACCEPT:    ptr <= '0;
        tcce_pkg::CMD_INIT_WR:   ptr <= ptr + ONE_A;
        tcce_pkg::CMD_PUT_WR:    cursor <= put_pos + ONE_A;
        tcce_pkg::CMD_OLD_WR:    cursor <= dest;
        tcce_pkg::CMD_DEL_START: ptr <= cursor;
        tcce_pkg::CMD_DEL_SHIFT: ptr <= ptr + ONE_A;
        tcce_pkg::CMD_CLR_WR: begin
          ptr    <= ptr + ONE_A;
          cursor <= '0;
        end
        default: ptr <= ptr;
      endcase
    end
  end

  // Operand, result and output payload registers.
  always_ff @(posedge clk) begin
    case (cmd)
      tcce_pkg::CMD_ACCEPT: begin
        char_q       <= char_code;
        attr_q       <= (op == tcce_pkg::OP_PUT) ? put_color : color;
        idx_q        <= cell_index;
        dest         <= dest_next;
        refused_flag <= blocked;
        res_char     <= '0;
        res_attr     <= '0;
      end
      tcce_pkg::CMD_OLD_WR: begin
        saved <= rdata[tcce_pkg::CELL_W-1:tcce_pkg::BYTE_W];
      end
      tcce_pkg::CMD_RD_CAPTURE: begin
        res_char <= idx_ok ? rdata[tcce_pkg::BYTE_W-1:0] : '0;
        res_attr <= idx_ok ? rdata[tcce_pkg::CELL_W-1:tcce_pkg::BYTE_W] : '0;
      end
      tcce_pkg::CMD_LOAD_OUT: begin
        cursor_now <= tcce_pkg::cursor_t'(cursor);
        refused    <= refused_flag;
        cell_char  <= res_char;
        cell_attr  <= res_attr;
      end
      default: begin
        saved <= saved;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/text_console_cursor_editor.sv]
// Top level of the text console cursor editor: configuration registers and wiring.
`default_nettype none

// Text-mode screen store of 80 x 25 character/attribute cells plus one invisible
// cell past the end, with a cursor. Each input beat carries one operation (write,
// put, clear, four cursor moves, delete, backspace, read) and yields exactly one
// result beat with the cursor after the operation, a refused flag for blocked
// moves or backspaces, and the cell contents for a read. Items are handled one at
// a time; the cell store has one write and one registered read port, so the cost
// is set by how many cells an operation touches. Clear walks all 2000 visible
// cells, and delete or backspace copy every cell after the cursor, one per cycle.
// The output register lets a new beat be accepted while the previous result
// still waits. After reset the block runs a clearing pass over the whole store,
// invisible cell included, holding in_stall high; configuration writes are
// accepted at all times (cfg_ready is always high) but must only be made while
// the block is idle.
module text_console_cursor_editor (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire tcce_pkg::op_t        op,
  input  wire tcce_pkg::byte_t      char_code,
  input  wire tcce_pkg::byte_t      color,
  input  wire tcce_pkg::index_t     cell_index,
  output logic                      out_valid,
  input  wire                       out_stall,
  output tcce_pkg::cursor_t         cursor_now,
  output logic                      refused,
  output tcce_pkg::byte_t           cell_char,
  output tcce_pkg::byte_t           cell_attr,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire tcce_pkg::cfg_idx_t   cfg_index,
  input  wire tcce_pkg::byte_t      cfg_data
);

  tcce_pkg::byte_t   put_color;
  tcce_pkg::byte_t   cursor_mark_attr;
  tcce_pkg::byte_t   plain_attr;
  tcce_pkg::cmd_t    cmd;
  tcce_pkg::status_t status;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  // Configuration registers. An index beyond the register list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      put_color        <= tcce_pkg::PUT_COLOR_RST;
      cursor_mark_attr <= tcce_pkg::CURSOR_MARK_RST;
      plain_attr       <= tcce_pkg::PLAIN_ATTR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcce_pkg::CFG_PUT_COLOR:   put_color        <= cfg_data;
        tcce_pkg::CFG_CURSOR_MARK: cursor_mark_attr <= cfg_data;
        tcce_pkg::CFG_PLAIN_ATTR:  plain_attr       <= cfg_data;
        default:                   plain_attr       <= plain_attr;
      endcase
    end
  end

  // The controller steps through the cells an operation needs and issues one
  // command per cycle; the datapath owns the store, the cursor and the result.
  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  tcce_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .op               (op),
    .char_code        (char_code),
    .color            (color),
    .cell_index       (cell_index),
    .put_color        (put_color),
    .cursor_mark_attr (cursor_mark_attr),
    .plain_attr       (plain_attr),
    .out_stall        (out_stall),
    .status           (status),
    .out_valid        (out_valid),
    .cursor_now       (cursor_now),
    .refused          (refused),
    .cell_char        (cell_char),
    .cell_attr        (cell_attr)
  );

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the text console cursor editor: stimulus, prediction, checks.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcce_pkg::*;

  // The watchdog limit covers the clearing pass after reset plus every beat taking the
  // slowest path (a full-screen delete or clear) with the longest gaps and stalls,
  // several times over.
  localparam int CYCLE_LIMIT    = 3_000_000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int TAIL_CYCLES    = 64;
  localparam int LAST_ROW_START = SCREEN_CELLS - COLUMNS;

  // Op codes past read do nothing; the stimulus still sends them.
  localparam op_t      OP_SPARE_FIRST = OP_READ + 4'd1;
  localparam op_t      OP_SPARE_LAST  = '1;
  // Register index with no register behind it.
  localparam cfg_idx_t CFG_SPARE      = '1;

  typedef struct packed {
    op_t    op;
    byte_t  char_code;
    byte_t  color;
    index_t cell_index;
  } keystroke_t;

  typedef struct packed {
    cursor_t cursor;
    logic    refused;
    byte_t   cell_char;
    byte_t   cell_attr;
  } screen_result_t;

  logic     clk        = 1'b0;
  logic     rst        = 1'b1;
  logic     in_valid   = 1'b0;
  logic     in_stall;
  op_t      op         = '0;
  byte_t    char_code  = '0;
  byte_t    color      = '0;
  index_t   cell_index = '0;
  logic     out_valid;
  logic     out_stall  = 1'b0;
  cursor_t  cursor_now;
  logic     refused;
  byte_t    cell_char;
  byte_t    cell_attr;
  logic     cfg_valid  = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index  = '0;
  byte_t    cfg_data   = '0;

  text_console_cursor_editor dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .char_code  (char_code),
    .color      (color),
    .cell_index (cell_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cursor_now (cursor_now),
    .refused    (refused),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the screen, the cursor and the three attribute registers.
  // The extra entry at SCREEN_CELLS is the invisible cell past the end.
  // ---------------------------------------------------------------------------
  cell_t shadow_cells [0:SCREEN_CELLS] = '{default: '0};
  int    shadow_cursor    = 0;
  byte_t shadow_put_color = PUT_COLOR_RST;
  byte_t shadow_mark      = CURSOR_MARK_RST;
  byte_t shadow_plain     = PLAIN_ATTR_RST;

  keystroke_t     keystroke_q[$];      // beats waiting for the driver
  screen_result_t pending_results[$];  // predicted result beats, oldest first

  int  mismatches  = 0;
  int  cycle_count = 0;
  bit  calm        = 1'b0;  // set for the last part of the run: no gaps, no stalls
  bit  beat_taken  = 1'b0;
  int  gap_left    = 0;
  int  gap_pct     = 25;
  int  beats_sent  = 0;
  int  stall_left  = 0;
  int  stall_pct   = 10;
  int  sink_cycles = 0;

  // Attribute writes aimed past the invisible cell are dropped.
  function automatic void paint_attr(int idx, byte_t attr);
    if (idx <= SCREEN_CELLS) begin
      shadow_cells[idx][CELL_W-1:BYTE_W] = attr;
    end
  endfunction

  // A write at or past the end of the screen wraps to the top-left cell first.
  function automatic void type_cell(byte_t ch, byte_t attr);
    if (shadow_cursor >= SCREEN_CELLS) begin
      shadow_cursor = 0;
    end
    shadow_cells[shadow_cursor] = {attr, ch};
    shadow_cursor++;
  endfunction

  // A move takes the attribute of the old cell along and leaves the plain
  // attribute behind.
  function automatic void carry_cursor(int dest);
    byte_t saved;
    saved = shadow_cells[shadow_cursor][CELL_W-1:BYTE_W];
    paint_attr(shadow_cursor, shadow_plain);
    shadow_cursor = dest;
    paint_attr(shadow_cursor, saved);
  endfunction

  // Cells after the cursor slide left one place in ascending order, the last
  // visible cell empties, and the cursor cell gets the mark. On the invisible
  // cell nothing slides; that cell is cleared and then marked.
  function automatic void delete_under_cursor();
    int k;
    if (shadow_cursor >= SCREEN_CELLS) begin
      shadow_cells[SCREEN_CELLS] = '0;
    end else begin
      for (k = shadow_cursor; k + 1 < SCREEN_CELLS; k++) begin
        shadow_cells[k] = shadow_cells[k+1];
      end
      shadow_cells[SCREEN_CELLS-1] = '0;
    end
    paint_attr(shadow_cursor, shadow_mark);
  endfunction

  // Applies one keystroke to the shadow state and returns the result beat that
  // the block must give for it.
  function automatic screen_result_t console_apply(keystroke_t ks);
    screen_result_t r;
    int k;
    r = '0;
    case (ks.op)
      OP_WRITE: begin
        type_cell(ks.char_code, ks.color);
      end
      OP_PUT: begin
        type_cell(ks.char_code, shadow_put_color);
        paint_attr(shadow_cursor, shadow_mark);
      end
      OP_CLEAR: begin
        // The invisible cell survives a clear.
        for (k = 0; k < SCREEN_CELLS; k++) begin
          shadow_cells[k] = '0;
        end
        shadow_cursor = 0;
        paint_attr(0, shadow_mark);
      end
      OP_LEFT: begin
        if (shadow_cursor == 0) r.refused = 1'b1;
        else carry_cursor(shadow_cursor - 1);
      end
      OP_RIGHT: begin
        if (shadow_cursor + 1 >= SCREEN_CELLS) r.refused = 1'b1;
        else carry_cursor(shadow_cursor + 1);
      end
      OP_UP: begin
        if (shadow_cursor < COLUMNS) r.refused = 1'b1;
        else carry_cursor(shadow_cursor - COLUMNS);
      end
      OP_DOWN: begin
        if (shadow_cursor + COLUMNS >= SCREEN_CELLS) r.refused = 1'b1;
        else carry_cursor(shadow_cursor + COLUMNS);
      end
      OP_DELETE: begin
        delete_under_cursor();
      end
      OP_BKSP: begin
        if (shadow_cursor == 0) begin
          r.refused = 1'b1;
        end else begin
          carry_cursor(shadow_cursor - 1);
          delete_under_cursor();
        end
      end
      OP_READ: begin
        // Indexes past the invisible cell read as zero.
        if (ks.cell_index <= SCREEN_CELLS) begin
          {r.cell_attr, r.cell_char} = shadow_cells[ks.cell_index];
        end
      end
      default: begin
      end
    endcase
    r.cursor = cursor_t'(shadow_cursor);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. A beat is taken at a rising edge with valid high and stall low;
  // the prediction is made right there, in acceptance order. The driver then
  // changes the payload at the following falling edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : accept_beat
    if (!rst && in_valid && !in_stall) begin
      pending_results.push_back(console_apply(keystroke_t'{op, char_code, color, cell_index}));
      beat_taken = 1'b1;
    end
  end

  // The payload only moves once the current beat is gone, so a stalled beat
  // holds still. After a beat the driver may sit idle for a burst of cycles;
  // the chance of a burst changes every 16 beats, zero included, so that there
  // are also stretches with back-to-back beats.
  always @(negedge clk) begin : drive_beat
    keystroke_t ks;
    if (!in_valid || beat_taken) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (keystroke_q.size() != 0) begin
        ks = keystroke_q.pop_front();
        op         <= ks.op;
        char_code  <= ks.char_code;
        color      <= ks.color;
        cell_index <= ks.cell_index;
        in_valid   <= 1'b1;
        beats_sent++;
        if (beats_sent % 16 == 0) begin
          case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 20;
            default: gap_pct = 60;
          endcase
        end
        if (!calm && $urandom_range(1, 100) <= gap_pct) begin
          gap_left = $urandom_range(1, 14);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side. Stall comes in bursts of random length whose likelihood is
  // redrawn from three settings, zero included, so some long stretches see no stall at all.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_stall
    sink_cycles++;
    if (sink_cycles % 512 == 0) begin
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 5;
        default: stall_pct = 30;
      endcase
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(1, 100) <= stall_pct) begin
      stall_left = $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Every result beat is held against the oldest prediction, field by field.
  always @(posedge clk) begin : check_result
    screen_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat expected none, got cursor %0d refused %0d char %0d attr %0d",
                 $time, cursor_now, refused, cell_char, cell_attr);
      end else begin
        want = pending_results.pop_front();
        check_field("cursor_now", want.cursor, cursor_now);
        check_field("refused", want.refused, refused);
        check_field("cell_char", want.cell_char, cell_char);
        check_field("cell_attr", want.cell_attr, cell_attr);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_console_cursor_editor: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic void push_key(op_t o, byte_t c, byte_t a, index_t i);
    keystroke_q.push_back(keystroke_t'{o, c, a, i});
  endfunction

  // Fields that the op does not use still carry random bits.
  function automatic void random_key(op_t o);
    push_key(o, byte_t'($urandom), byte_t'($urandom), index_t'($urandom));
  endfunction

  // Every op yields a result, so the block is idle once all predicted beats
  // have come back; the task then waits out DRAIN_CYCLES before touching registers.
  task automatic settle();
    do @(posedge clk);
    while (keystroke_q.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, byte_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      CFG_PUT_COLOR:   shadow_put_color = data;
      CFG_CURSOR_MARK: shadow_mark      = data;
      CFG_PLAIN_ATTR:  shadow_plain     = data;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Only downward moves and typing get the cursor far from the top-left cell.
  // This clears the screen, walks down to the last row (the last step is
  // refused), types the whole row with random content, ending with a put
  // that marks the invisible cell, and then works around the end of the
  // screen with random edits and reads.
  task automatic corner_trip();
    int k;
    op_t o;
    random_key(OP_CLEAR);
    repeat (ROWS) random_key(OP_DOWN);
    for (k = 0; k < COLUMNS; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        push_key(OP_READ, byte_t'($urandom), byte_t'($urandom),
                 index_t'($urandom_range(LAST_ROW_START, SCREEN_CELLS + 1)));
      end
      random_key((k == COLUMNS - 1 || $urandom_range(0, 3) == 0) ? OP_PUT : OP_WRITE);
    end
    random_key(OP_RIGHT);
    random_key(OP_DOWN);
    push_key(OP_READ, byte_t'($urandom), byte_t'($urandom), index_t'(SCREEN_CELLS));
    repeat (12) begin
      case ($urandom_range(0, 8))
        0: o = OP_WRITE;
        1: o = OP_PUT;
        2: o = OP_DELETE;
        3: o = OP_BKSP;
        4: o = OP_LEFT;
        5: o = OP_RIGHT;
        6: o = OP_UP;
        7: o = OP_DOWN;
        default: o = OP_READ;
      endcase
      if (o == OP_READ) begin
        push_key(o, byte_t'($urandom), byte_t'($urandom),
                 index_t'($urandom_range(LAST_ROW_START, (1 << INDEX_W) - 1)));
      end else begin
        random_key(o);
      end
    end
  endtask

  // A weighted mix of every op. Reads half of the time look at the top rows and otherwise
  // anywhere in the index range.
  task automatic mix_burst(int count);
    int roll;
    op_t o;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) o = OP_WRITE;
      else if (roll < 35) o = OP_PUT;
      else if (roll < 43) o = OP_LEFT;
      else if (roll < 51) o = OP_RIGHT;
      else if (roll < 58) o = OP_UP;
      else if (roll < 66) o = OP_DOWN;
      else if (roll < 72) o = OP_DELETE;
      else if (roll < 78) o = OP_BKSP;
      else if (roll < 80) o = OP_CLEAR;
      else if (roll < 95) o = OP_READ;
      else o = op_t'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      if (o == OP_READ && $urandom_range(0, 1) == 0) begin
        push_key(o, byte_t'($urandom), byte_t'($urandom),
                 index_t'($urandom_range(0, 2 * COLUMNS)));
      end else begin
        random_key(o);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run plan. A directed part under the reset register values, then four
  // phases, each under a different register setting: all zero, all ones,
  // and two random ones. The last phase runs without gaps or stalls.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reads of a freshly cleared store: first cell, invisible cell, top index.
    push_key(OP_READ, 8'h00, 8'h00, '0);
    push_key(OP_READ, 8'hFF, 8'hFF, index_t'(SCREEN_CELLS));
    push_key(OP_READ, 8'h00, 8'hFF, '1);
    // Moves and backspace that bump into the top-left corner.
    random_key(OP_LEFT);
    random_key(OP_UP);
    random_key(OP_BKSP);
    // Extreme character and color bytes, then a put that marks the cursor.
    push_key(OP_WRITE, 8'hFF, 8'h00, '0);
    push_key(OP_WRITE, 8'h00, 8'hFF, '1);
    push_key(OP_PUT, 8'hA5, 8'h5A, '0);
    // Each move carries the mark along and leaves the plain attribute.
    random_key(OP_LEFT);
    random_key(OP_RIGHT);
    random_key(OP_DOWN);
    random_key(OP_UP);
    push_key(OP_READ, 8'h00, 8'h00, index_t'(3));
    push_key(OP_READ, 8'h00, 8'h00, index_t'(2));
    random_key(OP_DELETE);
    push_key(OP_READ, 8'h00, 8'h00, index_t'(3));
    random_key(OP_BKSP);
    push_key(OP_READ, 8'h00, 8'h00, index_t'(2));
    // Codes past read change nothing.
    random_key(OP_SPARE_FIRST);
    random_key(OP_SPARE_LAST);
    random_key(OP_CLEAR);
    push_key(OP_READ, 8'h00, 8'h00, '0);
    push_key(OP_WRITE, 8'h5A, 8'hC3, '0);
    push_key(OP_READ, 8'h00, 8'h00, index_t'(SCREEN_CELLS - 1));
    push_key(OP_READ, 8'h00, 8'h00, index_t'(1 << (INDEX_W - 1)));
    settle();

    for (phase = 1; phase <= 4; phase++) begin
      case (phase)
        1: begin
          write_cfg(CFG_PUT_COLOR, 8'h00);
          write_cfg(CFG_CURSOR_MARK, 8'h00);
          write_cfg(CFG_PLAIN_ATTR, 8'h00);
        end
        2: begin
          write_cfg(CFG_PUT_COLOR, 8'hFF);
          write_cfg(CFG_CURSOR_MARK, 8'hFF);
          write_cfg(CFG_PLAIN_ATTR, 8'hFF);
          // A write to the unused index must leave every register alone.
          write_cfg(CFG_SPARE, byte_t'($urandom));
        end
        default: begin
          write_cfg(CFG_PUT_COLOR, byte_t'($urandom));
          write_cfg(CFG_CURSOR_MARK, byte_t'($urandom));
          write_cfg(CFG_PLAIN_ATTR, byte_t'($urandom));
        end
      endcase
      if (phase == 4) calm = 1'b1;
      if (phase % 2 == 1) corner_trip();
      else mix_burst(35);
      settle();
    end

    // Any result beat that shows up now has no prediction behind it.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("text_console_cursor_editor: match");
    end else begin
      $display("text_console_cursor_editor: mismatch");
    end
    $finish;
  end

endmodule
